/* design/scb_pkg.sv */
// ============================================================================
// scb_pkg - shared types and constants for the size-class buffer pool
// Opcodes, item kinds, result status codes and the queue entry layout.
// ============================================================================
`default_nettype none

package scb_pkg;

    localparam int ENTRIES_PER_TIER = 16;
    localparam int TIER_COUNT       = 4;
    localparam int HANDLE_BITS      = 32;

    // stored handle width: handles are masked to HANDLE_BITS, ports are 32 wide
    localparam int STORE_W    = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
    localparam int RAM_DEPTH  = TIER_COUNT * ENTRIES_PER_TIER;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);
    localparam int FILL_W     = $clog2(ENTRIES_PER_TIER + 1);
    localparam int TIER_W     = 3;
    localparam int TIER_IDX_W = $clog2(TIER_COUNT);
    localparam int LIMIT_W    = 24;
    localparam int CFG_IDX_W  = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TIER_W-1:0] OVERSIZE_TIER = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TIER0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIER1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIER2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIER3 = 2'd3;

    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_PUT   = 2'd1;
    localparam logic [1:0] OP_STATS = 2'd2;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_STORED  = 3'd2,
        ST_FREE    = 3'd3,
        ST_IGNORED = 3'd4,
        ST_STATS   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        K_GET    = 2'd0,
        K_PUT    = 2'd1,
        K_STATS  = 2'd2,
        K_IGNORE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [TIER_W-1:0]   tier;
        logic [31:0]         buf_size;
        logic [STORE_W-1:0]  handle;
    } t_entry;

endpackage

`default_nettype wire

/* design/scb_ram.sv */
// ============================================================================
// scb_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module scb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* design/scb_front.sv */
// ============================================================================
// scb_front - request intake and size-class selection
// Holds the tier limits, picks the tier and classifies each item.
// ============================================================================
`default_nettype none

module scb_front import scb_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LIMIT_W-1:0]   i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [31:0]          i_request_size,
    input  wire logic [31:0]          i_handle_in,
    input  wire logic                 i_full,
    output logic                      o_push,
    output t_entry                    o_entry
);

    logic [LIMIT_W-1:0] r_limit [TIER_COUNT];
    logic [TIER_W-1:0]  tier_sel;
    logic [STORE_W-1:0] handle_m;
    logic               size_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit[0] <= 24'd4096;
            r_limit[1] <= 24'd16384;
            r_limit[2] <= 24'd65536;
            r_limit[3] <= 24'd262144;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TIER0: r_limit[0] <= i_cfg_data;
                CFG_TIER1: r_limit[1] <= i_cfg_data;
                CFG_TIER2: r_limit[2] <= i_cfg_data;
                CFG_TIER3: r_limit[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // first tier in order whose limit covers the size
    always_comb begin
        tier_sel = OVERSIZE_TIER;
        for (int t = TIER_COUNT - 1; t >= 0; t--) begin
            if (i_request_size <= {8'b0, r_limit[t]}) begin
                tier_sel = TIER_W'(t);
            end
        end
    end

    assign handle_m = i_handle_in[STORE_W-1:0];
    assign size_nz  = (i_request_size != 32'd0);

    always_comb begin
        o_entry.tier   = tier_sel;
        o_entry.handle = handle_m;
        if (tier_sel == OVERSIZE_TIER) begin
            o_entry.buf_size = i_request_size;
        end else begin
            o_entry.buf_size = {8'b0, r_limit[tier_sel[TIER_IDX_W-1:0]]};
        end
        if (i_opcode == OP_GET && size_nz) begin
            o_entry.kind = K_GET;
        end else if (i_opcode == OP_PUT && size_nz && handle_m != '0) begin
            o_entry.kind = K_PUT;
        end else if (i_opcode == OP_STATS) begin
            o_entry.kind = K_STATS;
        end else begin
            o_entry.kind = K_IGNORE;
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

`default_nettype wire

/* design/scb_queue.sv */
// ============================================================================
// scb_queue - short queue between intake and execution
// Register-based FIFO of classified items.
// ============================================================================
`default_nettype none

module scb_queue import scb_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_entry      o_entry
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QCNT_W'(QUEUE_DEPTH)) || i_pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

/* design/scb_back.sv */
// ============================================================================
// scb_back - execution of classified items
// Per-tier handle stacks in RAM, fill counts, counters and the result register.
// ============================================================================
`default_nettype none

module scb_back import scb_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_entry i_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_handle_out,
    output logic [31:0] o_buf_size,
    output logic [2:0]  o_tier,
    output logic [31:0] o_hit_count,
    output logic [31:0] o_miss_count,
    output logic [31:0] o_return_count
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                r_state;
    logic [FILL_W-1:0]     r_fill [TIER_COUNT];
    logic [31:0]           r_hits;
    logic [31:0]           r_misses;
    logic [31:0]           r_returns;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [31:0]           r_out_handle;
    logic [31:0]           r_out_alloc;
    logic [TIER_W-1:0]     r_out_tier;
    logic [31:0]           r_out_hc;
    logic [31:0]           r_out_mc;
    logic [31:0]           r_out_rc;

    logic [TIER_IDX_W-1:0] t_idx;
    logic                  pooled;
    logic                  take;
    logic [FILL_W-1:0]     cur_fill;
    logic [FILL_W-1:0]     fill_dec;
    logic                  hit;
    logic                  store;
    logic [ADDR_W-1:0]     ram_addr;
    logic [STORE_W-1:0]    ram_rd_data;

    always_comb begin
        t_idx    = i_entry.tier[TIER_IDX_W-1:0];
        pooled   = (i_entry.tier != OVERSIZE_TIER);
        take     = i_valid && (r_state == S_IDLE) && (!r_out_valid || !i_stall);
        cur_fill = r_fill[t_idx];
        fill_dec = cur_fill - FILL_W'(1);
        hit      = (i_entry.kind == K_GET) && pooled && (cur_fill != '0);
        store    = (i_entry.kind == K_PUT) && pooled &&
                   (cur_fill < FILL_W'(ENTRIES_PER_TIER));
        // stack slot: tier base plus top-of-stack (pop) or next free (push)
        ram_addr = ADDR_W'(t_idx) * ADDR_W'(ENTRIES_PER_TIER) +
                   ADDR_W'(hit ? fill_dec : cur_fill);
    end

    scb_ram #(
        .WIDTH (STORE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (take && store),
        .i_wr_addr (ram_addr),
        .i_wr_data (i_entry.handle),
        .i_rd_en   (take && hit),
        .i_rd_addr (ram_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_returns   <= '0;
            for (int t = 0; t < TIER_COUNT; t++) begin
                r_fill[t] <= '0;
            end
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_READ) begin
                r_out_handle <= 32'(ram_rd_data);
                r_out_valid  <= 1'b1;
                r_state      <= S_IDLE;
            end else if (take) begin
                r_out_handle <= '0;
                r_out_alloc  <= '0;
                r_out_tier   <= '0;
                r_out_hc     <= '0;
                r_out_mc     <= '0;
                r_out_rc     <= '0;
                r_out_valid  <= 1'b1;
                case (i_entry.kind)
                    K_GET: begin
                        r_out_tier  <= i_entry.tier;
                        r_out_alloc <= i_entry.buf_size;
                        if (hit) begin
                            r_fill[t_idx] <= fill_dec;
                            r_hits        <= r_hits + 32'd1;
                            r_out_status  <= ST_HIT;
                            r_out_valid   <= 1'b0;
                            r_state       <= S_READ;
                        end else begin
                            r_misses     <= r_misses + 32'd1;
                            r_out_status <= ST_MISS;
                        end
                    end
                    K_PUT: begin
                        r_out_tier <= i_entry.tier;
                        if (store) begin
                            r_fill[t_idx] <= cur_fill + FILL_W'(1);
                            r_returns     <= r_returns + 32'd1;
                            r_out_status  <= ST_STORED;
                        end else begin
                            r_out_status <= ST_FREE;
                        end
                    end
                    K_STATS: begin
                        r_out_status <= ST_STATS;
                        r_out_hc     <= r_hits;
                        r_out_mc     <= r_misses;
                        r_out_rc     <= r_returns;
                    end
                    default: begin
                        r_out_status <= ST_IGNORED;
                    end
                endcase
            end
        end
    end

    assign o_pop          = take;
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_handle_out   = r_out_handle;
    assign o_buf_size     = r_out_alloc;
    assign o_tier         = r_out_tier;
    assign o_hit_count    = r_out_hc;
    assign o_miss_count   = r_out_mc;
    assign o_return_count = r_out_rc;

    a_read_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !r_out_valid)
        else $error("result pending while handle read in flight");

    a_hit_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && hit |=> r_state == S_READ)
        else $error("hit did not start handle read");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && hit |=> r_fill[$past(t_idx)] == $past(fill_dec))
        else $error("fill count not decremented on pop");

endmodule

`default_nettype wire

/* design/size_class_buffer_pool_top.sv */
// ============================================================================
// size_class_buffer_pool_top - four-tier free buffer handle pool
// Get, put and statistics requests against per-size-class handle stacks.
// ============================================================================
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ------------------------------
//  request   in         i_in_valid / o_in_stall    i_opcode, i_request_size,
//                                                  i_handle_in
//  result    out        o_out_valid / i_out_stall  o_status, o_handle_out,
//                                                  o_buf_size, o_tier,
//                                                  o_hit_count, o_miss_count,
//                                                  o_return_count
//  config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
//  Rate: one item per cycle while results are not held by i_out_stall, except
//  a get that hits, which holds the execute stage in its read state because the
//  popped handle comes out of the registered RAM read.
//  Reset: synchronous, active low; fill counts, counters and limits reset at
//  once, the handle RAM is not cleared (fill counts guard every read).
//  Stalls: a two-entry queue parts intake from execution, so two more requests
//  are still taken while a result waits on i_out_stall; then o_in_stall rises.
//
`default_nettype none

module size_class_buffer_pool_top import scb_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LIMIT_W-1:0]   i_cfg_data,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [31:0]          i_request_size,
    input  wire logic [31:0]          i_handle_in,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [2:0]                o_status,
    output logic [31:0]               o_handle_out,
    output logic [31:0]               o_buf_size,
    output logic [2:0]                o_tier,
    output logic [31:0]               o_hit_count,
    output logic [31:0]               o_miss_count,
    output logic [31:0]               o_return_count
);

    // classified item from intake into the queue
    t_entry front_entry;
    logic   front_push;
    logic   q_full;

    // queue head toward execution
    t_entry q_entry;
    logic   q_valid;
    logic   back_pop;

    // intake: tier limits, four parallel compares, item kind
    scb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_opcode       (i_opcode),
        .i_request_size (i_request_size),
        .i_handle_in    (i_handle_in),
        .i_full         (q_full),
        .o_push         (front_push),
        .o_entry        (front_entry)
    );

    // decoupling queue
    scb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // execution: stack push/pop, counters, result register
    scb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_entry        (q_entry),
        .o_pop          (back_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_status       (o_status),
        .o_handle_out   (o_handle_out),
        .o_buf_size     (o_buf_size),
        .o_tier         (o_tier),
        .o_hit_count    (o_hit_count),
        .o_miss_count   (o_miss_count),
        .o_return_count (o_return_count)
    );

endmodule

`default_nettype wire

/* bench/tb_size_class_buffer_pool_top.sv */
// ============================================================================
// tb_size_class_buffer_pool_top - self-checking bench for the buffer pool
// A short directed table (expected results typed in where obvious), then
// random get/put/stats traffic over several tier-limit settings. Every result
// is checked field by field against its typed value or an in-bench pool model.
// ============================================================================

module tb_size_class_buffer_pool_top import scb_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // opcode 3 has no meaning in the block: it must come back as ignored
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int LONG_HOLD       = 400;   // cycles of receiver hold-off
    localparam int HOLD_AFTER      = 300;   // items accepted before hold-off

    typedef struct packed {
        t_status     status;
        logic [31:0] handle_out;
        logic [31:0] buf_size;
        logic [2:0]  tier;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] return_count;
    } t_pool_result;

    // one line of the directed table
    typedef struct packed {
        logic [1:0]   op;
        logic [31:0]  size;
        logic [31:0]  hdl;
        bit           typed;    // result written out by hand below
        t_pool_result want;
    } t_req_row;

    // receiver stall styles
    typedef enum logic [1:0] {
        DRAIN_FREE,
        DRAIN_SPOTTY,
        DRAIN_HEAVY,
        DRAIN_COMB
    } t_drain_mode;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LIMIT_W-1:0]   i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_opcode;
    logic [31:0]          i_request_size;
    logic [31:0]          i_handle_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [2:0]           o_status;
    logic [31:0]          o_handle_out;
    logic [31:0]          o_buf_size;
    logic [2:0]           o_tier;
    logic [31:0]          o_hit_count;
    logic [31:0]          o_miss_count;
    logic [31:0]          o_return_count;

    size_class_buffer_pool_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_request_size (i_request_size),
        .i_handle_in    (i_handle_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_handle_out   (o_handle_out),
        .o_buf_size     (o_buf_size),
        .o_tier         (o_tier),
        .o_hit_count    (o_hit_count),
        .o_miss_count   (o_miss_count),
        .o_return_count (o_return_count)
    );

    // ------------------------------------------------------------------
    // Pool model state: limits, per-tier handle stacks, counters
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] tier_lim   [TIER_COUNT];
    logic [STORE_W-1:0] shelf      [TIER_COUNT][ENTRIES_PER_TIER];
    int unsigned        stack_fill [TIER_COUNT];
    logic [31:0]        hits_seen;
    logic [31:0]        misses_seen;
    logic [31:0]        returns_seen;

    t_pool_result owed_results [$];    // results the block still owes, oldest first
    t_req_row     script [$];          // directed table
    t_pool_result due_result;

    int           n_errors;
    int           n_accepted;
    int           burst_left;

    localparam logic [CFG_IDX_W-1:0] LIMIT_REG [TIER_COUNT] =
        '{CFG_TIER0, CFG_TIER1, CFG_TIER2, CFG_TIER3};

    // Apply one request to the model and return the result it produces.
    function automatic t_pool_result pool_respond(logic [1:0] op, logic [31:0] size,
                                                  logic [31:0] hdl);
        t_pool_result       r;
        logic [STORE_W-1:0] h;
        logic [2:0]         t;
        r        = '0;
        r.status = ST_IGNORED;
        h        = hdl[STORE_W-1:0];
        // first tier, lowest index, whose limit covers the size; a zero limit matches only a zero size
        t = OVERSIZE_TIER;
        for (int i = TIER_COUNT - 1; i >= 0; i--)
            if (size <= {8'h00, tier_lim[i]}) t = 3'(i);

        if (op == OP_GET && size != 0) begin
            r.tier = t;
            if (t != OVERSIZE_TIER && stack_fill[t] > 0) begin
                stack_fill[t]--;
                r.handle_out = 32'(shelf[t][stack_fill[t]]);
                r.buf_size   = {8'h00, tier_lim[t]};
                hits_seen    = hits_seen + 1;
                r.status     = ST_HIT;
            end else begin
                if (t != OVERSIZE_TIER) r.buf_size = {8'h00, tier_lim[t]};
                else                    r.buf_size = size;
                misses_seen = misses_seen + 1;
                r.status    = ST_MISS;
            end
        end else if (op == OP_PUT && size != 0 && h != 0) begin
            r.tier = t;
            if (t != OVERSIZE_TIER && stack_fill[t] < ENTRIES_PER_TIER) begin
                shelf[t][stack_fill[t]] = h;
                stack_fill[t]++;
                returns_seen = returns_seen + 1;
                r.status     = ST_STORED;
            end else begin
                r.status = ST_FREE;
            end
        end else if (op == OP_STATS) begin
            r.status       = ST_STATS;
            r.hit_count    = hits_seen;
            r.miss_count   = misses_seen;
            r.return_count = returns_seen;
        end
        return r;
    endfunction

    function automatic t_pool_result outcome(t_status st, logic [31:0] hout,
                                             logic [31:0] asize, int tr,
                                             logic [31:0] hc, logic [31:0] mc,
                                             logic [31:0] rc);
        t_pool_result r;
        r.status       = st;
        r.handle_out   = hout;
        r.buf_size     = asize;
        r.tier         = 3'(tr);
        r.hit_count    = hc;
        r.miss_count   = mc;
        r.return_count = rc;
        return r;
    endfunction

    task automatic add_row(logic [1:0] op, logic [31:0] size, logic [31:0] hdl,
                           bit typed, t_pool_result want);
        t_req_row r;
        r.op    = op;
        r.size  = size;
        r.hdl   = hdl;
        r.typed = typed;
        r.want  = want;
        script.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Sender: present one item, hold it until accepted, then log what the
    // block owes for it. Items come in bursts separated by random gaps;
    // valid stays high across back-to-back items.
    // ------------------------------------------------------------------
    task automatic offer(logic [1:0] op, logic [31:0] size, logic [31:0] hdl,
                         bit typed, t_pool_result want);
        int           gap;
        t_pool_result got;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap        = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_request_size <= size;
        i_handle_in    <= hdl;
        forever begin
            @(posedge i_clk);
            if (o_in_stall === 1'b0) break;
        end
        n_accepted++;
        got = pool_respond(op, size, hdl);
        owed_results.push_back(typed ? want : got);
    endtask

    // Stop sending and let the block empty out (results only, one per item).
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Receiver: switches between stall styles at random intervals, and
    // once, after HOLD_AFTER items, holds off for the LONG_HOLD span so the
    // internal queue fills and the input side must stall.
    // ------------------------------------------------------------------
    initial begin : drain_side
        t_drain_mode mode;
        int          left;
        int          hold;
        bit          held_once;
        i_out_stall = 1'b0;
        mode        = DRAIN_FREE;
        left        = 0;
        hold        = 0;
        held_once   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_once && n_accepted >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold      = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                if (left == 0) begin
                    mode = t_drain_mode'($urandom_range(3, 0));
                    left = $urandom_range(80, 10);
                end
                left--;
                case (mode)
                    DRAIN_FREE:   i_out_stall <= 1'b0;
                    DRAIN_SPOTTY: i_out_stall <= ($urandom_range(99, 0) < 30);
                    DRAIN_HEAVY:  i_out_stall <= ($urandom_range(99, 0) < 75);
                    default:      i_out_stall <= ((left % 4) < 2);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted result against the oldest owed one
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (owed_results.size() == 0) begin
                $display("%0t ns: result with none pending, expected none, actual status %0d",
                         $time, o_status);
                n_errors++;
            end else begin
                due_result = owed_results.pop_front();
                check_field("status",       32'(due_result.status),  32'(o_status));
                check_field("handle_out",   due_result.handle_out,   o_handle_out);
                check_field("buf_size",     due_result.buf_size,     o_buf_size);
                check_field("tier",         32'(due_result.tier),    32'(o_tier));
                check_field("hit_count",    due_result.hit_count,    o_hit_count);
                check_field("miss_count",   due_result.miss_count,   o_miss_count);
                check_field("return_count", due_result.return_count, o_return_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: far beyond the slowest legal run
    // ------------------------------------------------------------------
    initial begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stim
        logic [LIMIT_W-1:0] new_lim [TIER_COUNT];
        logic [1:0]         op;
        logic [31:0]        size;
        logic [31:0]        hdl;
        logic [31:0]        lim32;
        int                 put_pct;
        int                 focus;
        int                 t;
        int                 k;

        // all inputs known from time zero
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_TIER0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_GET;
        i_request_size = '0;
        i_handle_in    = '0;
        n_errors       = 0;
        n_accepted     = 0;
        burst_left     = 0;
        put_pct        = 50;
        focus          = 0;

        // model at reset
        tier_lim[0]  = 24'd4096;
        tier_lim[1]  = 24'd16384;
        tier_lim[2]  = 24'd65536;
        tier_lim[3]  = 24'd262144;
        hits_seen    = '0;
        misses_seen  = '0;
        returns_seen = '0;
        for (int i = 0; i < TIER_COUNT; i++) stack_fill[i] = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed table, default limits 4096/16384/65536/262144 ---
        // counters read zero straight after reset
        add_row(OP_STATS, 32'd0, 32'd0, 1'b1, outcome(ST_STATS, 0, 0, 0, 0, 0, 0));
        // zero size, null handle and the unused opcode are all ignored
        add_row(OP_GET, 32'd0, 32'd0, 1'b1, outcome(ST_IGNORED, 0, 0, 0, 0, 0, 0));
        add_row(OP_PUT, 32'd100, 32'd0, 1'b1, outcome(ST_IGNORED, 0, 0, 0, 0, 0, 0));
        add_row(OP_PUT, 32'd0, 32'h1234, 1'b1, outcome(ST_IGNORED, 0, 0, 0, 0, 0, 0));
        add_row(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                outcome(ST_IGNORED, 0, 0, 0, 0, 0, 0));
        // empty pool: smallest size misses on tier 0, largest is oversize
        add_row(OP_GET, 32'd1, 32'd0, 1'b1, outcome(ST_MISS, 0, 4096, 0, 0, 0, 0));
        add_row(OP_GET, 32'hFFFF_FFFF, 32'd0, 1'b1,
                outcome(ST_MISS, 0, 32'hFFFF_FFFF, OVERSIZE_TIER, 0, 0, 0));
        add_row(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                outcome(ST_FREE, 0, 0, OVERSIZE_TIER, 0, 0, 0));
        // puts on tier boundaries
        add_row(OP_PUT, 32'd4096, 32'hFFFF_FFFF, 1'b1, outcome(ST_STORED, 0, 0, 0, 0, 0, 0));
        add_row(OP_PUT, 32'd4097, 32'd1, 1'b1, outcome(ST_STORED, 0, 0, 1, 0, 0, 0));
        add_row(OP_PUT, 32'd262144, 32'hA5A5_A5A5, 1'b1, outcome(ST_STORED, 0, 0, 3, 0, 0, 0));
        add_row(OP_PUT, 32'd262145, 32'd7, 1'b1,
                outcome(ST_FREE, 0, 0, OVERSIZE_TIER, 0, 0, 0));
        // pop them back
        add_row(OP_GET, 32'd4096, 32'd0, 1'b1,
                outcome(ST_HIT, 32'hFFFF_FFFF, 4096, 0, 0, 0, 0));
        add_row(OP_GET, 32'd4096, 32'd0, 1'b1, outcome(ST_MISS, 0, 4096, 0, 0, 0, 0));
        add_row(OP_GET, 32'd16384, 32'd0, 1'b1, outcome(ST_HIT, 32'd1, 16384, 1, 0, 0, 0));
        add_row(OP_GET, 32'd65536, 32'd0, 1'b1, outcome(ST_MISS, 0, 65536, 2, 0, 0, 0));
        add_row(OP_GET, 32'd200000, 32'd0, 1'b1,
                outcome(ST_HIT, 32'hA5A5_A5A5, 262144, 3, 0, 0, 0));
        add_row(OP_STATS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                outcome(ST_STATS, 0, 0, 0, 3, 4, 3));
        // stack order, left to the model
        add_row(OP_PUT, 32'd65537, 32'h5A5A_5A5A, 1'b0, '0);
        add_row(OP_PUT, 32'd300, 32'h8000_0000, 1'b0, '0);
        add_row(OP_PUT, 32'd301, 32'h0000_0001, 1'b0, '0);
        add_row(OP_GET, 32'd2, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(OP_GET, 32'd4000, 32'd0, 1'b0, '0);
        add_row(OP_GET, 32'd262144, 32'd0, 1'b0, '0);
        add_row(OP_STATS, 32'd0, 32'd0, 1'b0, '0);

        foreach (script[i])
            offer(script[i].op, script[i].size, script[i].hdl, script[i].typed,
                  script[i].want);

        // --- random phases, each under its own tier limits ---
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph > 0) begin
                // limits only change while nothing is in flight
                wait_idle();
                case (ph)
                    1: new_lim = '{24'd1, 24'd2, 24'd3, 24'hFF_FFFF};
                    2: new_lim = '{24'd65536, 24'd4096, 24'hFF_FFFF, 24'd100};  // out of order
                    3: new_lim = '{24'd0, 24'd256, 24'd0, 24'hFF_FFFF};         // dead tiers
                    4: new_lim = '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF};
                    5: for (int i = 0; i < TIER_COUNT; i++)
                           new_lim[i] = 24'($urandom_range(24'hFF_FFFF, 1));
                    default: new_lim = '{24'd16, 24'd64, 24'd256, 24'd1024};
                endcase
                for (int i = 0; i < TIER_COUNT; i++) begin
                    @(negedge i_clk);
                    i_cfg_we    <= 1'b1;
                    i_cfg_index <= LIMIT_REG[i];
                    i_cfg_data  <= new_lim[i];
                    @(posedge i_clk);
                    tier_lim[i] = new_lim[i];
                end
                @(negedge i_clk);
                i_cfg_we <= 1'b0;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // switch at random between fill and drain windows so stacks reach both full and empty
                if (n % 48 == 0) begin
                    put_pct = ($urandom_range(1, 0) == 1) ? 65 : 20;
                    focus   = $urandom_range(TIER_COUNT - 1, 0);
                end

                k = $urandom_range(99, 0);
                if (k < 2)                 op = OP_UNUSED;
                else if (k < 8)            op = OP_STATS;
                else if (k < 8 + put_pct)  op = OP_PUT;
                else                       op = OP_GET;

                // sizes cluster on the focus tier and around its limit
                t     = ($urandom_range(99, 0) < 70) ? focus : $urandom_range(TIER_COUNT - 1, 0);
                lim32 = {8'h00, tier_lim[t]};
                k     = $urandom_range(99, 0);
                if (k < 4)        size = 32'd0;
                else if (k < 12)  size = $urandom;
                else if (k < 20)  size = lim32 + 1;
                else if (k < 35)  size = lim32;
                else if (k < 40)  size = 32'd1;
                else              size = (lim32 == 0) ? 32'd1 : $urandom_range(lim32, 1);

                hdl = ($urandom_range(99, 0) < 5) ? 32'd0 : $urandom;
                offer(op, size, hdl, 1'b0, '0);
            end
        end

        // all sent: let the owed results come home, then report the verdict
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
